// File: src/gcd_pkg.sv
//------------------------------------------------------------------------------
// gcd_pkg: shared types, constants and helpers of the great circle distance block
// Holds the CORDIC arctangent table, fixed-point widths and the gain constant.
//------------------------------------------------------------------------------
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;    // fraction bits of the degree inputs
    localparam int ACC_W   = 40;            // CORDIC accumulator width
    localparam int DIST_W  = 22;
    localparam int RAD_W   = 16;
    localparam logic signed [ACC_W-1:0] CordicGain = 40'sd652032874;
    localparam logic signed [ACC_W-1:0] OneQ30     = 40'sd1073741824;
    localparam logic [DIST_W-1:0]       DistMax    = 22'h3FFFFF;
    localparam logic [RAD_W-1:0]        RadiusReset = 16'd3440;
    localparam logic [74:0]             DegToRadQ32 = 75'd74961321;

    // One CORDIC step's operands, carried from cell to cell.
    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
        logic [1:0]              quad;
    } cordic_t;

    function automatic logic signed [ACC_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ACC_W-1:0] r;
        begin
            case (i)
                5'd0: r = 40'sd843314856;
                5'd1: r = 40'sd497837829;
                5'd2: r = 40'sd263043836;
                5'd3: r = 40'sd133525158;
                5'd4: r = 40'sd67021686;
                5'd5: r = 40'sd33543515;
                5'd6: r = 40'sd16775850;
                5'd7: r = 40'sd8388437;
                5'd8: r = 40'sd4194282;
                5'd9: r = 40'sd2097149;
                5'd10: r = 40'sd1048575;
                5'd11: r = 40'sd524287;
                5'd12: r = 40'sd262143;
                5'd13: r = 40'sd131071;
                5'd14: r = 40'sd65535;
                5'd15: r = 40'sd32767;
                5'd16: r = 40'sd16383;
                5'd17: r = 40'sd8191;
                5'd18: r = 40'sd4095;
                5'd19: r = 40'sd2047;
                5'd20: r = 40'sd1023;
                5'd21: r = 40'sd511;
                5'd22: r = 40'sd255;
                5'd23: r = 40'sd127;
                5'd24: r = 40'sd63;
                5'd25: r = 40'sd31;
                5'd26: r = 40'sd15;
                5'd27: r = 40'sd7;
                5'd28: r = 40'sd3;
                5'd29: r = 40'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: src/gcd_cordic_cell.sv
//------------------------------------------------------------------------------
// gcd_cordic_cell: one CORDIC micro-rotation cell
// Rotation or vectoring step with a fixed shift, registered toward the next cell.
//------------------------------------------------------------------------------
module gcd_cordic_cell #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic            clk,
    input  logic            en,
    input  gcd_pkg::cordic_t din,
    output gcd_pkg::cordic_t dout
);
    import gcd_pkg::*;

    cordic_t cell_reg;
    cordic_t cell_next;
    logic    dir_pos;
    logic signed [ACC_W-1:0] xs;
    logic signed [ACC_W-1:0] ys;
    logic signed [ACC_W-1:0] at;

    always_comb
    begin
        xs = din.x >>> STAGE;
        ys = din.y >>> STAGE;
        at = atan_q30(5'(STAGE));
        dir_pos = VECTORING ? (din.y >= 0) : (din.z >= 0);
        cell_next.quad = din.quad;
        if (dir_pos != VECTORING)
        begin
            // rotate counterclockwise
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
        end
        else
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
        end
        if (dir_pos)
            cell_next.z = VECTORING ? din.z + at : din.z - at;
        else
            cell_next.z = VECTORING ? din.z - at : din.z + at;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;
endmodule

// File: src/gcd_sincos.sv
//------------------------------------------------------------------------------
// gcd_sincos: quadrant reduction, degree to radian conversion and a row of
// rotation cells giving cosine and sine in Q30.
//------------------------------------------------------------------------------
module gcd_sincos #(
    parameter int CORDIC_STAGES   = 24,
    parameter int FB              = 16,
    parameter int DEG_W           = 26
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [DEG_W-1:0]         deg,
    output logic signed [gcd_pkg::ACC_W-1:0] cos_q30,
    output logic signed [gcd_pkg::ACC_W-1:0] sin_q30
);
    import gcd_pkg::*;

    localparam int ST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int RW = FB + 10;
    localparam logic signed [RW:0] Quarter = (RW+1)'(90) <<< FB;

    // Stage A: reduction into [0, 360) then quadrant; deg stays within +-720.
    logic signed [RW:0] r;
    logic [1:0]         q;
    logic [RW:0]        rem;
    logic [RW:0]        rem_reg;
    logic [1:0]         q_reg;
    logic [RW+40:0]     prod;
    cordic_t            c0;
    cordic_t            chain [ST+1];

    always_comb
    begin
        r = (RW+1)'(deg);
        // reduce by repeated 360 degree steps (at most two)
        if (r < 0)
            r = r + ((RW+1)'(360) <<< FB);
        if (r < 0)
            r = r + ((RW+1)'(360) <<< FB);
        if (r >= ((RW+1)'(360) <<< FB))
            r = r - ((RW+1)'(360) <<< FB);
        if (r >= ((RW+1)'(360) <<< FB))
            r = r - ((RW+1)'(360) <<< FB);
        if (r >= 3 * Quarter)
            q = 2'd3;
        else if (r >= 2 * Quarter)
            q = 2'd2;
        else if (r >= Quarter)
            q = 2'd1;
        else
            q = 2'd0;
        rem = (RW+1)'(r - $signed({1'b0, q}) * Quarter);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem;
            q_reg   <= q;
        end
    end

    // Stage B: conversion to radians.
    always_comb
    begin
        prod   = (RW+41)'(rem_reg) * (RW+41)'(DegToRadQ32);
        prod   = (prod + ((RW+41)'(1) << (FB + 1))) >> (FB + 2);
        c0.x   = CordicGain;
        c0.y   = '0;
        c0.z   = ACC_W'(prod);
        c0.quad = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            chain[0] <= c0;
    end

    for (genvar i = 0; i < ST; i++)
    begin : g_cell
        gcd_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_cell (
            .clk  (clk),
            .en   (en),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    always_comb
    begin
        case (chain[ST].quad)
            2'd0:    begin cos_q30 = chain[ST].x;  sin_q30 = chain[ST].y;  end
            2'd1:    begin cos_q30 = -chain[ST].y; sin_q30 = chain[ST].x;  end
            2'd2:    begin cos_q30 = -chain[ST].x; sin_q30 = -chain[ST].y; end
            default: begin cos_q30 = chain[ST].y;  sin_q30 = -chain[ST].x; end
        endcase
    end
endmodule

// File: src/gcd_sqrt_cell.sv
//------------------------------------------------------------------------------
// gcd_sqrt_cell: one digit step of a restoring square root, two lanes
//------------------------------------------------------------------------------
module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [60:0] va,
    input  logic [30:0] ra,
    input  logic [60:0] vb,
    input  logic [30:0] rb,
    output logic [60:0] va_out,
    output logic [30:0] ra_out,
    output logic [60:0] vb_out,
    output logic [30:0] rb_out
);
    localparam int SH = 2 * (30 - STEP);

    logic [61:0] ta;
    logic [61:0] tb;
    logic [60:0] va_reg, vb_reg;
    logic [30:0] ra_reg, rb_reg;

    // trial: (4*root + 1) << (2*k) against the remainder
    always_comb
    begin
        ta = ({29'd0, ra, 2'b01}) << SH;
        tb = ({29'd0, rb, 2'b01}) << SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if ({1'b0, va} >= ta)
            begin
                va_reg <= 61'({1'b0, va} - ta);
                ra_reg <= {ra[29:0], 1'b1};
            end
            else
            begin
                va_reg <= va;
                ra_reg <= {ra[29:0], 1'b0};
            end
            if ({1'b0, vb} >= tb)
            begin
                vb_reg <= 61'({1'b0, vb} - tb);
                rb_reg <= {rb[29:0], 1'b1};
            end
            else
            begin
                vb_reg <= vb;
                rb_reg <= {rb[29:0], 1'b0};
            end
        end
    end

    assign va_out = va_reg;
    assign ra_out = ra_reg;
    assign vb_out = vb_reg;
    assign rb_out = rb_reg;
endmodule

// File: src/great_circle_distance.sv
//------------------------------------------------------------------------------
// great_circle_distance: haversine distance of two positions, fully pipelined
//
//  channel   | dir | payload
//  s_axis    | in  | from_lat, from_lon, to_lat, to_lon (degrees, Q16)
//  m_axis    | out | distance (nautical miles, Q8)
//  cfg       | in  | earth_radius_nm
//
//  One item per cycle while the output buffer is not full; an item passes through
//  four rotation chains in parallel, product stages, 31 square root cells and
//  a vectoring chain.
//  A result that waits moves into a one-item output buffer; the whole pipe and
//  the input stand only while that buffer is full.
//  Reset clears valid flags and sets the radius to 3440.
//------------------------------------------------------------------------------
module great_circle_distance #(
    parameter int CORDIC_STAGES   = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [23:0] from_latitude, [48:24] from_longitude, [72:49] to_latitude,
    // [97:73] to_longitude, [103:98] zero
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [21:0] distance, [23:22] zero
    output logic [23:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    import gcd_pkg::*;

    localparam int ST  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = 3 + ST + 1 + 1 + 31 + 1 + ST + 2;

    logic [RAD_W-1:0] radius_reg;
    logic [LAT-1:0]   vld_reg;
    logic             hold_vld_reg;
    logic             en;

    assign en            = !hold_vld_reg;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = hold_vld_reg || vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RadiusReset;
            vld_reg      <= '0;
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                radius_reg <= cfg_data;
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            if (hold_vld_reg)
            begin
                if (m_axis_tready)
                    hold_vld_reg <= 1'b0;
            end
            else if (vld_reg[LAT-1] && !m_axis_tready)
                hold_vld_reg <= 1'b1;
        end
    end

    logic signed [23:0] lat1, lat2;
    logic signed [24:0] lon1, lon2;
    logic signed [25:0] dlat, dlon, lat1_reg, lat2_reg, dlat_reg, dlon_reg;

    assign lat1 = s_axis_tdata[23:0];
    assign lon1 = s_axis_tdata[48:24];
    assign lat2 = s_axis_tdata[72:49];
    assign lon2 = s_axis_tdata[97:73];
    assign dlat = 26'(lat2) - 26'(lat1);
    assign dlon = 26'(lon2) - 26'(lon1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= 26'(lat1);
            lat2_reg <= 26'(lat2);
            dlat_reg <= dlat;
            dlon_reg <= dlon;
        end
    end

    logic signed [ACC_W-1:0] cdl, sdl, cdo, sdo, c1, s1, c2, s2;

    gcd_sincos #(.CORDIC_STAGES(ST),
                 .FB(ANGLE_FRAC_BITS+1), .DEG_W(26)) u_sc_dlat (
        .clk(clk), .en(en), .deg(dlat_reg), .cos_q30(cdl), .sin_q30(sdl));
    gcd_sincos #(.CORDIC_STAGES(ST),
                 .FB(ANGLE_FRAC_BITS+1), .DEG_W(26)) u_sc_dlon (
        .clk(clk), .en(en), .deg(dlon_reg), .cos_q30(cdo), .sin_q30(sdo));
    gcd_sincos #(.CORDIC_STAGES(ST),
                 .FB(ANGLE_FRAC_BITS), .DEG_W(26)) u_sc_lat1 (
        .clk(clk), .en(en), .deg(lat1_reg), .cos_q30(c1), .sin_q30(s1));
    gcd_sincos #(.CORDIC_STAGES(ST),
                 .FB(ANGLE_FRAC_BITS), .DEG_W(26)) u_sc_lat2 (
        .clk(clk), .en(en), .deg(lat2_reg), .cos_q30(c2), .sin_q30(s2));

    // Haversine products, one level of multiplies per register stage. Sines, cosines and
    // their products stay within unit range, so 32-bit operands suffice.
    logic signed [ACC_W-1:0] hl_reg, ho_reg, cc_reg, a_reg;
    logic signed [63:0] p_hl, p_ho, p_cc, p_a;

    always_comb
    begin
        p_hl = (64'($signed(sdl[31:0])) * 64'($signed(sdl[31:0]))
                + 64'sd536870912) >>> 30;
        p_ho = (64'($signed(sdo[31:0])) * 64'($signed(sdo[31:0]))
                + 64'sd536870912) >>> 30;
        p_cc = (64'($signed(c1[31:0])) * 64'($signed(c2[31:0]))
                + 64'sd536870912) >>> 30;
        p_a  = (64'($signed(cc_reg[31:0])) * 64'($signed(ho_reg[31:0]))
                + 64'sd536870912) >>> 30;
    end

    logic signed [ACC_W-1:0] a_sum;
    always_comb
    begin
        a_sum = hl_reg + ACC_W'(p_a);
        if (a_sum < 0)
            a_sum = '0;
        if (a_sum > OneQ30)
            a_sum = OneQ30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hl_reg  <= ACC_W'(p_hl);
            ho_reg  <= ACC_W'(p_ho);
            cc_reg  <= ACC_W'(p_cc);
            a_reg   <= a_sum;
        end
    end

    // Square roots of a<<30 and (1-a)<<30, one result bit per cell.
    logic [60:0] va [32];
    logic [60:0] vb [32];
    logic [30:0] ra [32];
    logic [30:0] rb [32];

    assign va[0] = {a_reg[30:0], 30'd0};
    assign vb[0] = {31'(OneQ30 - a_reg), 30'd0};
    assign ra[0] = '0;
    assign rb[0] = '0;

    for (genvar k = 0; k < 31; k++)
    begin : g_sqrt
        gcd_sqrt_cell #(.STEP(k)) u_sq (
            .clk(clk), .en(en),
            .va(va[k]), .ra(ra[k]), .vb(vb[k]), .rb(rb[k]),
            .va_out(va[k+1]), .ra_out(ra[k+1]), .vb_out(vb[k+1]), .rb_out(rb[k+1]));
    end

    cordic_t vchain [ST+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vchain[0].x    <= ACC_W'(rb[31]);
            vchain[0].y    <= ACC_W'(ra[31]);
            vchain[0].z    <= '0;
            vchain[0].quad <= '0;
        end
    end

    for (genvar v = 0; v < ST; v++)
    begin : g_vec
        gcd_cordic_cell #(.STAGE(v), .VECTORING(1'b1)) u_vc (
            .clk(clk), .en(en), .din(vchain[v]), .dout(vchain[v+1]));
    end

    logic [ACC_W-1:0]  ang_reg;
    logic [ACC_W+16:0] dprod;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] hold_reg;

    always_comb
    begin
        dprod = ((ACC_W+17)'(ang_reg) * (ACC_W+17)'(radius_reg)
                 + (ACC_W+17)'(2097152)) >> 22;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg  <= (vchain[ST].z < 0) ? '0 : ACC_W'(vchain[ST].z <<< 1);
            dist_reg <= (dprod > (ACC_W+17)'(DistMax)) ? DistMax : DIST_W'(dprod);
        end
    end

    // The pipe moves on under a refused result, so that result is parked here.
    always_ff @(posedge clk)
    begin
        if (!hold_vld_reg && vld_reg[LAT-1] && !m_axis_tready)
            hold_reg <= dist_reg;
    end

    assign m_axis_tdata = {2'b00, hold_vld_reg ? hold_reg : dist_reg};

    logic unused_sc;
    assign unused_sc = ^{cdl, cdo, s1, s2, s_axis_tdata[103:98], va[31], vb[31]};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST+4] |-> (a_reg >= 0 && a_reg <= OneQ30))
        else $error("haversine term out of range");
endmodule

// File: test/great_circle_distance_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Great circle distance checker
// Watches the coordinate, distance and radius channels, computes the
// expected haversine distance of each accepted item in fixed point and
// compares every accepted distance item against the oldest expected one.
//------------------------------------------------------------------------------
module great_circle_distance_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [23:0]  m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    output int           error_count,
    output int           pending_count
);
    import gcd_pkg::*;

    localparam int FRAC_BITS = ANGLE_FRAC_BITS;
    localparam int STAGES    = 24;

    logic [15:0]       radius_nm;
    logic [DIST_W-1:0] expected_distances[$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Rotation-mode CORDIC on a quadrant-reduced angle in degrees.
    function automatic void trig_of_degrees(input longint deg, input int fb,
                                            output longint cos_q30,
                                            output longint sin_q30);
        longint full_turn;
        longint quarter;
        longint r;
        longint rem;
        longint x;
        longint y;
        longint z;
        longint nx;
        int     quad;
        full_turn = longint'(360) << fb;
        quarter   = longint'(90) << fb;
        r = deg % full_turn;
        if (r < 0)
            r += full_turn;
        quad = int'(r / quarter) & 3;
        rem = r - longint'(quad) * quarter;
        z = (rem * 74961321 + (longint'(1) << (fb + 1))) >>> (fb + 2);
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z  = z - longint'(atan_q30(5'(i)));
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z  = z + longint'(atan_q30(5'(i)));
            end
            x = nx;
        end
        case (quad)
            0: begin cos_q30 = x;  sin_q30 = y;  end
            1: begin cos_q30 = -y; sin_q30 = x;  end
            2: begin cos_q30 = -x; sin_q30 = -y; end
            default: begin cos_q30 = y; sin_q30 = -x; end
        endcase
    endfunction

    function automatic longint vector_angle_q30(longint x, longint y);
        longint z;
        longint nx;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z  = z + longint'(atan_q30(5'(i)));
            end
            else
            begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z  = z - longint'(atan_q30(5'(i)));
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [DIST_W-1:0] haversine_distance(logic [103:0] coords,
                                                             logic [15:0] radius);
        longint lat1;
        longint lon1;
        longint lat2;
        longint lon2;
        longint c1, s1, c2, s2, cdl, sdl, cdo, sdo;
        longint hl, ho, cc, a, ang, sa, sb;
        longint unsigned d;
        lat1 = longint'($signed(coords[23:0]));
        lon1 = longint'($signed(coords[48:24]));
        lat2 = longint'($signed(coords[72:49]));
        lon2 = longint'($signed(coords[97:73]));
        trig_of_degrees(lat2 - lat1, FRAC_BITS + 1, cdl, sdl);
        trig_of_degrees(lon2 - lon1, FRAC_BITS + 1, cdo, sdo);
        trig_of_degrees(lat1, FRAC_BITS, c1, s1);
        trig_of_degrees(lat2, FRAC_BITS, c2, s2);
        hl = (sdl * sdl + (64'sd1 <<< 29)) >>> 30;
        ho = (sdo * sdo + (64'sd1 <<< 29)) >>> 30;
        cc = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
        a = hl + ((cc * ho + (64'sd1 <<< 29)) >>> 30);
        if (a < 0)
            a = 0;
        if (a > (64'sd1 <<< 30))
            a = 64'sd1 <<< 30;
        sa = int_sqrt(longint'(a) << 30);
        sb = int_sqrt(longint'((64'sd1 <<< 30) - a) << 30);
        ang = 2 * vector_angle_q30(sb, sa);
        if (ang < 0)
            ang = 0;
        d = (longint'(ang) * radius + (64'd1 << 21)) >> 22;
        if (d > DistMax)
            d = DistMax;
        return d[DIST_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    initial
    begin
        error_count = 0;
        pending_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_nm <= RadiusReset;
            expected_distances.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radius_nm <= cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_distances.size() == 0)
                    report_mismatch($sformatf("unexpected distance %0d", m_axis_tdata[21:0]));
                else
                begin
                    if (m_axis_tdata[21:0] !== expected_distances[0])
                        report_mismatch($sformatf("distance got %0d want %0d",
                                                  m_axis_tdata[21:0], expected_distances[0]));
                    void'(expected_distances.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_distances.push_back(haversine_distance(s_axis_tdata, radius_nm));
            pending_count = expected_distances.size();
        end
    end
endmodule

// File: test/tb_great_circle_distance.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Great circle distance testbench
// Drives directed and random coordinate pairs under several earth radius
// settings with random idling on both streams; a separate checker predicts
// and compares the distances.
//------------------------------------------------------------------------------
module tb_great_circle_distance;
    import gcd_pkg::*;

    localparam int LAT_MAX   = 5898240;
    localparam int LON_MAX   = 11796480;
    localparam int STALL_MAX = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;
    int           error_count;
    int           pending_count;
    int           idle_cycles;
    bit           quiet_phase;

    great_circle_distance dut (.*);

    great_circle_distance_checker checker_i (.*);

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // The receiver stalls about 9 percent of the time except during the quiet phase.
    always @(posedge clk)
        m_axis_tready <= quiet_phase || ($urandom_range(99) >= 9);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [103:0] pack_coords(int lat1, int lon1, int lat2, int lon2);
        return {6'd0, 25'(lon2), 24'(lat2), 25'(lon1), 24'(lat1)};
    endfunction

    task automatic send_item(input logic [103:0] coords);
        while (!quiet_phase && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= coords;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_radius(input logic [15:0] radius);
        cfg_valid <= 1'b1;
        cfg_data  <= radius;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int rand_signed(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly legal positions; every so often a field spans its whole bit range.
    function automatic logic [103:0] random_coords();
        logic [103:0] c;
        c = pack_coords(rand_signed(LAT_MAX), rand_signed(LON_MAX),
                        rand_signed(LAT_MAX), rand_signed(LON_MAX));
        if ($urandom_range(9) == 0)
            c[97:0] = 98'({$urandom(), $urandom(), $urandom(), $urandom()});
        if ($urandom_range(9) == 0)
            c[97:49] = c[48:0];
        return c;
    endfunction

    initial
    begin
        logic [15:0] radii[5];
        radii = '{16'd3440, 16'd1, 16'd65535, 16'd0, 16'd3959};
        rst_n = 1'b0;
        quiet_phase = 1'b0;
        idle_cycles = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, poles, antipodes, same point, wrapped angles.
        send_item(pack_coords(0, 0, 0, 0));
        send_item(pack_coords(LAT_MAX, 0, -LAT_MAX, 0));
        send_item(pack_coords(0, -LON_MAX, 0, LON_MAX));
        send_item(pack_coords(0, 0, 0, LON_MAX));
        send_item(pack_coords(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
        send_item(pack_coords(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX));
        send_item(pack_coords(3342336, -7667712, 2424832, 917504));
        send_item(pack_coords(-8388608, -16777216, 8388607, 16777215));
        send_item(pack_coords(8388607, 16777215, -8388608, -16777216));
        send_item(pack_coords(1, 1, 0, 0));
        send_item(pack_coords(-1, -1, 0, 0));
        send_item(pack_coords(LAT_MAX, 0, LAT_MAX, 1));
        send_item({104{1'b1}});
        drain_pipe();

        foreach (radii[r])
        begin
            write_radius(radii[r]);
            quiet_phase = (r == 2);
            for (int i = 0; i < 260; i++)
                send_item(random_coords());
            quiet_phase = 1'b0;
            drain_pipe();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: sim.f
src/gcd_pkg.sv
src/gcd_cordic_cell.sv
src/gcd_sincos.sv
src/gcd_sqrt_cell.sv
src/great_circle_distance.sv
test/great_circle_distance_checker.sv
test/tb_great_circle_distance.sv
